// ===== design/upc_pkg.sv =====
// ----------------------------------------------------------------------------
// upc_pkg
// Types, character codes and character-class helpers for the URI percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam int ByteW    = 8;
  localparam int QueueLen = 5;  // room for two waiting bytes plus one full escape
  localparam int MaxRes   = 3;

  localparam logic [ByteW-1:0] CH_PCT   = 8'h25;
  localparam logic [ByteW-1:0] CH_QUERY = 8'h3F;
  localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;

  localparam logic MODE_ENCODE = 1'b0;

  localparam logic [1:0] ESC_IDLE   = 2'd0;
  localparam logic [1:0] ESC_FIRST  = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } q_entry_t;

  function automatic logic is_safe(input logic [ByteW-1:0] c);
    logic r;
    r = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h30 && c <= 8'h39);
    case (c)
      8'h2F, 8'h3A, 8'h2E, 8'h2D, 8'h5F, 8'h21, 8'h7E, 8'h27, 8'h28,
      8'h29, 8'h40, 8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h26, 8'h2A: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_hex(input logic [ByteW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else begin
      v = 4'(c - 8'h57);
    end
    return v;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'(n) + 8'h30) : (8'(n) + 8'h37);
  endfunction

  // strtol-style base-16 parse of up to two characters, modulo 256
  // st: 0 space allowed, 1 sign allowed, 2 digits, 3 stopped
  function automatic logic [ByteW-1:0] parse_escape(input logic [ByteW-1:0] c0,
                                                    input logic [ByteW-1:0] c1,
                                                    input logic [1:0]       n);
    logic [1:0]       st;
    logic             neg;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] ch;
    st  = 2'd0;
    neg = 1'b0;
    acc = '0;
    for (int k = 0; k < 2; k++) begin
      ch = (k == 0) ? c0 : c1;
      if (2'(k) < n) begin
        if (st == 2'd0 && is_space(ch)) begin
          st = 2'd1;
        end else if (st <= 2'd1 && (ch == CH_PLUS || ch == CH_MINUS)) begin
          neg = (ch == CH_MINUS);
          st  = 2'd2;
        end else if (st <= 2'd2 && is_hex(ch)) begin
          acc = {acc[3:0], hex_val(ch)};
          st  = 2'd2;
        end else begin
          st = 2'd3;
        end
      end
    end
    return neg ? (8'd0 - acc) : acc;
  endfunction

endpackage

// ===== design/uri_percent_codec.sv =====
// ----------------------------------------------------------------------------
// uri_percent_codec
// Byte-stream URI percent encoder / decoder with a five-entry output queue.
// ----------------------------------------------------------------------------
// One input transaction is taken per cycle while the output queue holds two
// bytes or fewer; its results are written to the queue registers at the same
// edge and leave from the registered queue head, one byte per cycle while
// out_tready is high. Pass-through and decoded bytes sustain one input byte
// per cycle unless the output stalls; an escaped byte in encode mode gives
// three output bytes, so such a stream is held to the output port's rate.
// The mode bit (0 encode, 1 decode) is written through cfg_wen / cfg_wdata
// and must only change while the codec is idle.
module uri_percent_codec
  import upc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wen,
  input  logic             cfg_wdata,   // mode
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ByteW-1:0] in_tdata,    // [7:0] in_byte
  input  logic             in_tlast,    // in_last
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ByteW-1:0] out_tdata,   // [7:0] out_byte
  output logic             out_tlast    // out_last
);

  localparam int CntW = $clog2(QueueLen + 1);

  logic             mode_r;
  logic             query_r, query_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [ByteW-1:0] first_r, first_nxt;

  q_entry_t         q_r   [QueueLen];
  q_entry_t         q_nxt [QueueLen];
  logic [CntW-1:0]  count_r, count_nxt;

  q_entry_t         res   [MaxRes];
  logic [1:0]       nres;
  logic             push, pop;
  logic [CntW-1:0]  base;
  logic [ByteW-1:0] c;

  assign in_tready  = (count_r <= CntW'(2));
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = q_r[0].data;
  assign out_tlast  = q_r[0].last;
  assign push       = in_tvalid && in_tready;
  assign pop        = out_tvalid && out_tready;

  // per-byte codec step
  always_comb begin
    nres      = 2'd0;
    query_nxt = query_r;
    phase_nxt = phase_r;
    first_nxt = first_r;
    c         = in_tdata;
    for (int j = 0; j < MaxRes; j++) begin
      res[j] = '{data: '0, last: 1'b0};
    end
    if (mode_r == MODE_ENCODE) begin
      query_nxt = 1'b0;
      phase_nxt = ESC_IDLE;
      first_nxt = '0;
      if (is_safe(c)) begin
        nres   = 2'd1;
        res[0] = '{data: c, last: in_tlast};
      end else begin
        nres   = 2'd3;
        res[0] = '{data: CH_PCT, last: 1'b0};
        res[1] = '{data: hex_char(c[7:4]), last: 1'b0};
        res[2] = '{data: hex_char(c[3:0]), last: in_tlast};
      end
    end else begin
      case (phase_r)
        ESC_FIRST: begin
          if (in_tlast) begin
            nres      = 2'd1;
            res[0]    = '{data: parse_escape(c, '0, 2'd1), last: 1'b1};
            query_nxt = 1'b0;
            phase_nxt = ESC_IDLE;
            first_nxt = '0;
          end else begin
            first_nxt = c;
            phase_nxt = ESC_SECOND;
          end
        end
        ESC_SECOND: begin
          nres      = 2'd1;
          res[0]    = '{data: parse_escape(first_r, c, 2'd2), last: in_tlast};
          phase_nxt = ESC_IDLE;
          first_nxt = '0;
          if (in_tlast) begin
            query_nxt = 1'b0;
          end
        end
        default: begin
          phase_nxt = ESC_IDLE;
          if (c == CH_PCT) begin
            if (in_tlast) begin
              nres      = 2'd1;
              res[0]    = '{data: '0, last: 1'b1};
              query_nxt = 1'b0;
              first_nxt = '0;
            end else begin
              phase_nxt = ESC_FIRST;
            end
          end else begin
            nres = 2'd1;
            if (c == CH_QUERY) begin
              query_nxt = 1'b1;
            end else if (c == CH_PLUS && query_r) begin
              c = CH_SPACE;
            end
            res[0] = '{data: c, last: in_tlast};
            if (in_tlast) begin
              query_nxt = 1'b0;
              first_nxt = '0;
            end
          end
        end
      endcase
    end
  end

  // output queue: shift out at the head, append after the survivors
  always_comb begin
    base = count_r - CntW'(pop);
    for (int i = 0; i < QueueLen; i++) begin
      if (pop && i < QueueLen - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push && (CntW'(i) >= base) && ((CntW'(i) - base) < CntW'(nres))) begin
        q_nxt[i] = res[2'(CntW'(i) - base)];
      end
    end
    count_nxt = base + (push ? CntW'(nres) : CntW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ENCODE;
      query_r <= 1'b0;
      phase_r <= ESC_IDLE;
      first_r <= '0;
      count_r <= '0;
    end else begin
      if (cfg_wen) begin
        mode_r <= cfg_wdata;
      end
      if (push) begin
        query_r <= query_nxt;
        phase_r <= phase_nxt;
        first_r <= first_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueLen; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule
